// ===== rtl/orrt_pkg.sv =====
// Shared types, codes and field widths of the ordered range rule table.
package orrt_pkg;

  localparam int RULE_ENTRIES_DEF = 64;

  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 16;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 3;
  localparam int POS_W      = 6;
  localparam int HELD_W     = 7;
  localparam int IN_DATA_W  = 144;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 3;

  // command codes
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL = 2'd1;
  localparam logic [OP_W-1:0] OP_CHK = 2'd2;

  // result codes
  localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_ACCEPTED  = 3'd5;
  localparam logic [STAT_W-1:0] ST_REJECTED  = 3'd6;

  // one table entry; hi bounds equal lo bounds for single values
  typedef struct packed {
    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] hi_addr;
    logic [PORT_W-1:0] lo_port;
    logic [PORT_W-1:0] hi_port;
    logic [1:0]        flags;    // bit 0 address range, bit 1 port range
  } rule_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_run;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic chk_hit;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/orrt_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module orrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/orrt_ctrl.sv =====
// Command sequencer of the rule table: accept, decode, scan, result.
module orrt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  orrt_pkg::stat_t stat,
  output orrt_pkg::cmd_t  cmd
);
  import orrt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.scan_clr = 1'b1;
        state_nxt    = stat.need_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done || stat.chk_hit) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result issued while output register busy");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan_clr, cmd.scan_run, cmd.emit}))
    else $error("more than one command at once");

  a_ready_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> in_tready)
    else $error("not ready after result");

endmodule

// ===== rtl/orrt_dp.sv =====
// Datapath of the rule table: item register, rule memory, scan, count, result.
module orrt_dp #(
  parameter int RULE_ENTRIES = orrt_pkg::RULE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  orrt_pkg::cmd_t                      cmd,
  output orrt_pkg::stat_t                     stat,
  input  logic [orrt_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [orrt_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [orrt_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [orrt_pkg::OUT_USER_W-1:0]     out_tuser
);
  import orrt_pkg::*;

  localparam int AW     = $clog2(RULE_ENTRIES);
  localparam int CW     = $clog2(RULE_ENTRIES + 1);
  localparam int XW     = (CW > HELD_W) ? CW : HELD_W;
  localparam int RULE_W = $bits(rule_t);
  localparam logic [CW-1:0] FULL_CNT = CW'(RULE_ENTRIES);

  // latched item
  logic [OP_W-1:0]   op_r;
  rule_t             item_r;
  logic [ADDR_W-1:0] qa_r;
  logic [PORT_W-1:0] qp_r;

  // table state and scan pointers
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r;
  logic          cmp_vld_r;
  logic [AW-1:0] cmp_idx_r;
  logic          found_r;
  logic [AW-1:0] match_idx_r;

  // output register
  logic              out_valid_r;
  logic [STAT_W-1:0] out_stat_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [HELD_W-1:0] out_held_r;

  logic              is_del, is_chk;
  logic              port_bad, add_bad, is_full, is_empty;
  logic              issue, covers, equal, hit, shift_we;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  rule_t             ram_wdata, ram_rd;
  logic [RULE_W-1:0] ram_rdata;
  logic [STAT_W-1:0] res_status;
  logic [AW-1:0]     res_idx;
  logic [XW-1:0]     pos_ext, held_ext;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r           <= in_tuser[1:0];
      item_r.lo_addr <= in_tdata[31:0];
      item_r.hi_addr <= in_tuser[2] ? in_tdata[63:32] : in_tdata[31:0];
      item_r.lo_port <= in_tdata[79:64];
      item_r.hi_port <= in_tuser[3] ? in_tdata[95:80] : in_tdata[79:64];
      item_r.flags   <= in_tuser[3:2];
      qa_r           <= in_tdata[127:96];
      qp_r           <= in_tdata[143:128];
    end
  end

  assign is_del   = (op_r == OP_DEL);
  assign is_chk   = (op_r == OP_CHK);
  assign port_bad = item_r.flags[1] && (item_r.lo_port >= item_r.hi_port);
  assign add_bad  = port_bad || (item_r.flags[0] && (item_r.lo_addr >= item_r.hi_addr));
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  assign stat.need_scan = ((is_del && !port_bad) || is_chk) && !is_empty;

  // scan: one read per cycle, compare on the registered read data
  assign ram_rd   = rule_t'(ram_rdata);
  assign issue    = cmd.scan_run && (rd_idx_r < count_r);
  assign covers   = (qa_r >= ram_rd.lo_addr) && (qa_r <= ram_rd.hi_addr) &&
                    (qp_r >= ram_rd.lo_port) && (qp_r <= ram_rd.hi_port);
  assign equal    = (ram_rd == item_r);
  assign hit      = cmp_vld_r && !found_r && (is_chk ? covers : equal);
  // after the match, every later entry moves up one place
  assign shift_we = cmd.scan_run && cmp_vld_r && found_r && is_del;

  assign stat.chk_hit   = cmp_vld_r && is_chk && covers;
  assign stat.scan_done = (rd_idx_r >= count_r) && !cmp_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else if (cmd.scan_clr) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else if (cmd.scan_run) begin
      cmp_vld_r <= issue;
      if (issue) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      if (hit) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx_r <= rd_idx_r[AW-1:0];
    end
    if (cmd.scan_run && hit) begin
      match_idx_r <= cmp_idx_r;
    end
  end

  always_comb begin
    case (op_r)
      OP_ADD: begin
        if (add_bad) begin
          res_status = ST_INVALID;
        end else if (is_full) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_ADDED;
        end
      end
      OP_DEL: begin
        if (port_bad) begin
          res_status = ST_INVALID;
        end else begin
          res_status = found_r ? ST_DELETED : ST_NOT_FOUND;
        end
      end
      OP_CHK:  res_status = found_r ? ST_ACCEPTED : ST_REJECTED;
      default: res_status = ST_INVALID;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    res_idx   = '0;
    case (res_status)
      ST_ADDED: begin
        res_idx = count_r[AW-1:0];
        if (cmd.emit) begin
          count_nxt = count_r + CW'(1);
        end
      end
      ST_DELETED: begin
        res_idx = match_idx_r;
        if (cmd.emit) begin
          count_nxt = count_r - CW'(1);
        end
      end
      ST_ACCEPTED: res_idx = match_idx_r;
      default:     res_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign ram_we    = shift_we || (cmd.emit && (res_status == ST_ADDED));
  assign ram_waddr = shift_we ? (cmp_idx_r - AW'(1)) : count_r[AW-1:0];
  assign ram_wdata = shift_we ? ram_rd : item_r;

  orrt_ram #(
    .WIDTH (RULE_W),
    .DEPTH (RULE_ENTRIES)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign pos_ext  = XW'(res_idx);
  assign held_ext = XW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_stat_r <= res_status;
      out_pos_r  <= pos_ext[POS_W-1:0];
      out_held_r <= held_ext[HELD_W-1:0];
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tuser     = out_stat_r;
  assign out_tdata     = OUT_DATA_W'({out_held_r, out_pos_r});

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("rule count above table size");

  a_shift_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    shift_we |-> (found_r && !cmd.emit))
    else $error("entry moved before a match");

  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (res_status == ST_ADDED)) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("add did not grow the table");

endmodule

// ===== rtl/ordered_range_rule_table_top.sv =====
// Top level of the ordered range rule table (firewall ACL range match).
//
//  channel | dir | tdata (low bit first)                       | tuser (low bit first)
//  --------+-----+---------------------------------------------+--------------------------
//  in_     | in  | lo addr 32, hi addr 32, lo port 16,         | opcode 2, addr is range 1,
//          |     | hi port 16, query addr 32, query port 16    | port is range 1
//  out_    | out | rule position 6, rules held 7, 3 zero bits  | status 3
//
//  Add, invalid and full skip the scan and go from accept to decode to result.
//  Delete and check walk the rule RAM from entry 0, one read per cycle; a check
//  stops at the first entry that covers the query; an empty table or an invalid delete skips the walk.
//  Delete moves every later entry up one place during that same walk.
//  Synchronous active-low reset empties the table; the RAM is not cleared.
//  A new item is taken while an earlier result waits on out_; the next result
//  waits in its final state until the output register is free.
module ordered_range_rule_table_top #(
  parameter int RULE_ENTRIES = orrt_pkg::RULE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [orrt_pkg::IN_DATA_W-1:0]  in_tdata,  // lo_addr, hi_addr, lo_port, hi_port,
                                                     // query_addr, query_port
  input  logic [orrt_pkg::IN_USER_W-1:0]  in_tuser,  // opcode, address_is_range,
                                                     // port_is_range
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [orrt_pkg::OUT_DATA_W-1:0] out_tdata, // rule_position, rules_held, zero pad
  output logic [orrt_pkg::OUT_USER_W-1:0] out_tuser  // status
);
  import orrt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: one command item at a time
  orrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // rule memory, count, compare logic and output register
  orrt_dp #(
    .RULE_ENTRIES (RULE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/sv/orrt_checker.sv =====
// Checker for the rule table: follows both channels, predicts each result and compares.
module orrt_checker #(
  parameter int RULE_ENTRIES = orrt_pkg::RULE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [orrt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [orrt_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [orrt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [orrt_pkg::OUT_USER_W-1:0] out_tuser,
  output int                              failures,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import orrt_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [HELD_W-1:0] held;
  } outcome_t;

  rule_t    rule_table [RULE_ENTRIES];
  int       table_fill;
  outcome_t pending_outcomes [$];

  initial begin
    failures    = 0;
    outstanding = 0;
    table_fill  = 0;
  end

  // Applies one command to the shadow table and returns the result it gives.
  function automatic outcome_t apply_command(input logic [IN_DATA_W-1:0] d,
                                             input logic [IN_USER_W-1:0] u);
    rule_t             cand;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] q_addr;
    logic [PORT_W-1:0] q_port;
    outcome_t          res;
    int                hit;
    op           = u[1:0];
    cand.flags   = u[3:2];
    cand.lo_addr = d[31:0];
    cand.hi_addr = cand.flags[0] ? d[63:32] : d[31:0];
    cand.lo_port = d[79:64];
    cand.hi_port = cand.flags[1] ? d[95:80] : d[79:64];
    q_addr       = d[127:96];
    q_port       = d[143:128];
    res.status   = ST_INVALID;
    res.position = '0;
    hit          = -1;
    case (op)
      OP_ADD: begin
        if ((cand.flags[0] && cand.lo_addr >= cand.hi_addr) ||
            (cand.flags[1] && cand.lo_port >= cand.hi_port)) begin
          res.status = ST_INVALID;
        end else if (table_fill >= RULE_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          rule_table[table_fill] = cand;
          res.status   = ST_ADDED;
          res.position = POS_W'(table_fill);
          table_fill++;
        end
      end
      OP_DEL: begin
        if (cand.flags[1] && cand.lo_port >= cand.hi_port) begin
          res.status = ST_INVALID;
        end else begin
          for (int i = 0; i < table_fill; i++)
            if (hit < 0 && rule_table[i] == cand) hit = i;
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            for (int j = hit; j + 1 < table_fill; j++) rule_table[j] = rule_table[j+1];
            table_fill--;
            res.status   = ST_DELETED;
            res.position = POS_W'(hit);
          end
        end
      end
      OP_CHK: begin
        for (int i = 0; i < table_fill; i++)
          if (hit < 0 && q_addr >= rule_table[i].lo_addr && q_addr <= rule_table[i].hi_addr &&
              q_port >= rule_table[i].lo_port && q_port <= rule_table[i].hi_port)
            hit = i;
        if (hit < 0) begin
          res.status = ST_REJECTED;
        end else begin
          res.status   = ST_ACCEPTED;
          res.position = POS_W'(hit);
        end
      end
      default: res.status = ST_INVALID;
    endcase
    res.held = HELD_W'(table_fill);
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst_n) begin
      // results leave only after their command has been accepted, so order here is free
      if (out_tvalid && out_tready) begin
        got.status   = out_tuser[2:0];
        got.position = out_tdata[5:0];
        got.held     = out_tdata[12:6];
        if (pending_outcomes.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with none expected: status %0d pos %0d held %0d",
                     $realtime, got.status, got.position, got.held);
        end else begin
          want = pending_outcomes.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d (status/pos/held)",
                       $realtime, want.status, want.position, want.held,
                       got.status, got.position, got.held);
          end
        end
      end
      if (in_tvalid && in_tready) pending_outcomes.push_back(apply_command(in_tdata, in_tuser));
      outstanding = pending_outcomes.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the ordered range rule table: stimulus, idling and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import orrt_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RULE_ENTRIES = 64;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CALM_ITEMS   = 300;      // tail of the run with no idling at all
  localparam int HOLD_AT_ITEM = 600;      // where the long receiver hold-off starts
  localparam int LONG_HOLD    = 400;      // cycles of out_tready low, far beyond one scan
  localparam int DRAIN_CYCLES = 2 * RULE_ENTRIES + 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int POOL_DEPTH   = 200;

  // the fourth opcode has no meaning; the block must answer invalid
  localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

  // one command item before packing
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] hi_addr;
    logic              addr_rng;
    logic [PORT_W-1:0] lo_port;
    logic [PORT_W-1:0] hi_port;
    logic              port_rng;
    logic [ADDR_W-1:0] q_addr;
    logic [PORT_W-1:0] q_port;
  } command_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  int          fail_count;
  int          outstanding;
  int unsigned cycle_count   = 0;
  int          send_gap_pct  = 0;      // chance of an idle burst before each item
  bit          calm          = 1'b0;   // set for the tail: neither side idles
  bit          hold_request  = 1'b0;   // sender asks the receiver for one long hold-off

  // rules recently offered for adding; deletes and checks are drawn from here so
  // that they actually hit table entries
  command_t recent_rules [$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  ordered_range_rule_table_top #(
    .RULE_ENTRIES(RULE_ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  orrt_checker #(
    .RULE_ENTRIES(RULE_ENTRIES)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .failures   (fail_count),
    .outstanding(outstanding)
  );

  // ---------------------------------------------------------------------------
  // Command builders
  // ---------------------------------------------------------------------------

  function automatic command_t mk(input logic [OP_W-1:0] op,
                                  input logic [31:0] la, input logic [31:0] ha,
                                  input logic ar,
                                  input logic [15:0] lp, input logic [15:0] hp,
                                  input logic pr,
                                  input logic [31:0] qa, input logic [15:0] qp);
    command_t c;
    c.op = op;  c.lo_addr = la;  c.hi_addr = ha;  c.addr_rng = ar;
    c.lo_port = lp;  c.hi_port = hp;  c.port_rng = pr;
    c.q_addr = qa;  c.q_port = qp;
    return c;
  endfunction

  // every field random: the unused ones still toggle every bit
  function automatic command_t noise_command();
    command_t c;
    c = mk(OP_W'($urandom), $urandom, $urandom, 1'($urandom), 16'($urandom),
           16'($urandom), 1'($urandom), $urandom, 16'($urandom));
    return c;
  endfunction

  // value in [0, top]: ends, a crowded neighborhood (to get overlaps), or anything
  function automatic logic [31:0] draw_value(input logic [31:0] top, input logic [31:0] nearby);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:          v = '0;
      1:          v = top;
      2, 3, 4, 5: v = nearby + $urandom_range(0, 1023);
      default:    v = $urandom;
    endcase
    return v & top;
  endfunction

  // mostly ascending bounds; a few come out equal or reversed on purpose
  function automatic void draw_bounds(input logic [31:0] top, input logic [31:0] nearby,
                                      output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] a;
    logic [31:0] b;
    a = draw_value(top, nearby);
    b = $urandom_range(0, 1) ? draw_value(top, nearby) : a + $urandom_range(1, 300);
    if (b > top) b = top;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (lo == hi) begin
      if (hi != top) hi = hi + 1;
      else lo = lo - 1;
    end
    case ($urandom_range(0, 24))
      0:       hi = lo;          // degenerate range
      1:       {lo, hi} = {hi, lo};  // descending range
      default: ;
    endcase
  endfunction

  // a new rule for add or delete; single values keep a random high bound
  function automatic command_t fresh_rule(input logic [OP_W-1:0] op);
    command_t    c;
    logic [31:0] lo;
    logic [31:0] hi;
    c    = noise_command();
    c.op = op;
    if (c.addr_rng) begin
      draw_bounds(32'hFFFF_FFFF, 32'h0A00_0000, lo, hi);
      c.lo_addr = lo;
      c.hi_addr = hi;
    end else begin
      c.lo_addr = draw_value(32'hFFFF_FFFF, 32'h0A00_0000);
    end
    if (c.port_rng) begin
      draw_bounds(32'h0000_FFFF, 32'h0, lo, hi);
      c.lo_port = lo[15:0];
      c.hi_port = hi[15:0];
    end else begin
      c.lo_port = 16'(draw_value(32'h0000_FFFF, 32'h0));
    end
    return c;
  endfunction

  // query on a bound, just past the top, or anywhere inside
  function automatic logic [31:0] near_bound(input logic [31:0] lo, input logic [31:0] hi);
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0:       v = lo;
      1:       v = hi;
      2:       v = hi + 1;
      default: v = lo + 32'($urandom % (64'(hi - lo) + 64'd1));
    endcase
    return v;
  endfunction

  // add_pct steers the table toward full (high) or toward empty (low)
  function automatic command_t random_command(input int add_pct);
    command_t c;
    command_t r;
    int       roll;
    int       del_pct;
    del_pct = (97 - add_pct) / 2;
    roll    = $urandom_range(0, 99);
    if (roll < 3) begin
      c    = noise_command();
      c.op = OP_RSVD;
    end else if (roll < 3 + add_pct) begin
      c = fresh_rule(OP_ADD);
    end else if (roll < 3 + add_pct + del_pct) begin
      if (recent_rules.size() != 0 && $urandom_range(0, 4) != 0) begin
        c        = recent_rules[$urandom_range(0, recent_rules.size() - 1)];
        c.op     = OP_DEL;
        c.q_addr = $urandom;
        c.q_port = 16'($urandom);
        if (!c.addr_rng) c.hi_addr = $urandom;
        if (!c.port_rng) c.hi_port = 16'($urandom);
        // an odd flag flip: same numbers, different rule
        if ($urandom_range(0, 19) == 0) c.addr_rng = ~c.addr_rng;
      end else begin
        c = fresh_rule(OP_DEL);
      end
    end else begin
      c    = noise_command();
      c.op = OP_CHK;
      if (recent_rules.size() != 0 && $urandom_range(0, 9) < 7) begin
        r        = recent_rules[$urandom_range(0, recent_rules.size() - 1)];
        c.q_addr = near_bound(r.lo_addr, r.addr_rng ? r.hi_addr : r.lo_addr);
        c.q_port = 16'(near_bound(32'(r.lo_port), 32'(r.port_rng ? r.hi_port : r.lo_port)));
      end
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at the falling edge after accept
  // ---------------------------------------------------------------------------
  task automatic send_command(input command_t c);
    int gap;
    if (c.op == OP_ADD) begin
      recent_rules.push_back(c);
      if (recent_rules.size() > POOL_DEPTH) void'(recent_rules.pop_front());
    end
    if (!calm && send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      gap       = $urandom_range(1, 18);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    // tdata: lo_addr, hi_addr, lo_port, hi_port, query_addr, query_port (low first)
    in_tdata  <= {c.q_port, c.q_addr, c.hi_port, c.lo_port, c.hi_addr, c.lo_addr};
    // tuser: opcode, address_is_range, port_is_range (low first)
    in_tuser  <= {c.port_rng, c.addr_rng, c.op};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, none when calm
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    int recv_gap_pct;
    int tick;
    stall        = 0;
    recv_gap_pct = 0;
    tick         = 0;
    forever begin
      @(negedge clk);
      if (tick % 256 == 0) begin
        case ($urandom_range(0, 2))
          0:       recv_gap_pct = 0;
          1:       recv_gap_pct = 8;
          default: recv_gap_pct = 30;
        endcase
      end
      tick++;
      if (calm) stall = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (hold_request) begin
        // long hold-off: results back up, the block stops taking commands
        hold_request = 1'b0;
        stall        = LONG_HOLD - 1;
        out_tready   <= 1'b0;
      end else if (rst_n && !calm && $urandom_range(0, 99) < recv_gap_pct) begin
        stall      = $urandom_range(1, 18) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // run limit, far above the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ordered_range_rule_table_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table
    send_command(mk(OP_CHK, 32'hC0A8_0001, 0, 0, 0, 0, 0, 32'hC0A8_0001, 16'd80));
    send_command(mk(OP_DEL, 32'h0A00_0001, 0, 0, 16'd22, 0, 0, 0, 0));
    // extremes; high bound of a single value is junk and must be ignored
    send_command(mk(OP_ADD, 32'h0, 32'hFFFF_FFFF, 0, 16'h0, 16'hFFFF, 0,
                    32'hFFFF_FFFF, 16'hFFFF));
    send_command(mk(OP_ADD, 32'h0, 32'hFFFF_FFFF, 1, 16'h0, 16'hFFFF, 1, 0, 0));
    // ranges that are not strictly ascending, and reversed bounds on single values
    send_command(mk(OP_ADD, 32'h0A00_0005, 32'h0A00_0005, 1, 16'd10, 16'd20, 1, 0, 0));
    send_command(mk(OP_ADD, 32'hFFFF_FFFF, 32'h0, 1, 16'd10, 16'd20, 1, 0, 0));
    send_command(mk(OP_ADD, 32'd5, 32'd9, 1, 16'd443, 16'd443, 1, 0, 0));
    send_command(mk(OP_ADD, 32'd5, 32'd9, 1, 16'hFFFF, 16'h0, 1, 0, 0));
    send_command(mk(OP_ADD, 32'hFFFF_FFFF, 32'h0, 0, 16'hFFFF, 16'h0, 0, 0, 0));
    // first matching rule wins
    send_command(mk(OP_CHK, 0, 0, 0, 0, 0, 0, 32'h0, 16'h0));
    send_command(mk(OP_CHK, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 16'hFFFF));
    // unused opcode
    send_command(mk(OP_RSVD, '1, '1, 1, '1, '1, 1, '1, '1));
    // delete: descending port range is invalid, reversed address range just misses
    send_command(mk(OP_DEL, 32'h0, 32'hFFFF_FFFF, 1, 16'd100, 16'd50, 1, 0, 0));
    send_command(mk(OP_DEL, 32'hFFFF_FFFF, 32'h0, 1, 16'h0, 16'hFFFF, 1, 0, 0));
    send_command(mk(OP_DEL, 32'h0, 32'hFFFF_FFFF, 1, 16'h0, 16'hFFFF, 1, 0, 0));
    send_command(mk(OP_CHK, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 16'hFFFF));
    send_command(mk(OP_CHK, 0, 0, 0, 0, 0, 0, 32'd12345, 16'd7));
    send_command(mk(OP_DEL, 32'h0, 32'h1234_5678, 0, 16'h0, 16'h4321, 0, 0, 0));
    send_command(mk(OP_DEL, 32'h0, 32'h0, 0, 16'h0, 16'h0, 0, 0, 0));
    send_command(mk(OP_DEL, 32'hFFFF_FFFF, 32'h0, 0, 16'hFFFF, 16'h0, 0, 0, 0));
    // range edges of a mixed rule
    send_command(mk(OP_ADD, 32'h0A00_0000, 32'h0A00_00FF, 1, 16'd8080, 16'd0, 0, 0, 0));
    send_command(mk(OP_CHK, 0, 0, 0, 0, 0, 0, 32'h0A00_00FF, 16'd8080));
    send_command(mk(OP_CHK, 0, 0, 0, 0, 0, 0, 32'h0A00_0100, 16'd8080));
    send_command(mk(OP_CHK, 0, 0, 0, 0, 0, 0, 32'h0A00_0000, 16'd8081));

    // random: phases that fill the table to full, then drain it
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       send_gap_pct = 0;
          1:       send_gap_pct = 10;
          default: send_gap_pct = 35;
        endcase
      end
      if (n == HOLD_AT_ITEM) hold_request = 1'b1;
      send_command(random_command(((n / 250) % 2 == 0) ? 70 : 10));
    end
    in_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("ordered_range_rule_table_top test passed");
    end else begin
      $display("ordered_range_rule_table_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/orrt_pkg.sv
rtl/orrt_ram.sv
rtl/orrt_ctrl.sv
rtl/orrt_dp.sv
rtl/ordered_range_rule_table_top.sv
tb/sv/orrt_checker.sv
tb/sv/tb.sv
